// ----- design/mexp_pkg.sv -----
package mexp_pkg;

	// Width of the data ports, fixed by the interface.
	localparam int unsigned DATA_W = 32;

	// Status that the shared multiplier reports to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} mul_status_t;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_REDUCE = 5'b00010,
		S_ISSUE  = 5'b00100,
		S_MUL    = 5'b01000,
		S_SQR    = 5'b10000
	} seq_state_t;

endpackage

// ----- design/mexp_mulmod.sv -----
// Bit-serial modular multiplier: product = x * y mod m, one bit of y per cycle,
// most significant bit first. Requires x <= m and m != 0.
module mexp_mulmod #(
	parameter int unsigned N = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [N-1:0]          x,
	input  logic [N-1:0]          y,
	input  logic [N-1:0]          m,
	output mexp_pkg::mul_status_t status,
	output logic [N-1:0]          product
);

	localparam int unsigned W     = N + 2;
	localparam int unsigned CNT_W = (N > 1) ? $clog2(N) : 1;

	logic [N-1:0]     x_q;
	logic [N-1:0]     y_q;
	logic [N-1:0]     m_q;
	logic [N-1:0]     r_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [W-1:0] addend;
	logic [W-1:0] sum;
	logic [W-1:0] m1;
	logic [W-1:0] m2;
	logic [W-1:0] reduced;

	// One step: r = 2r + bit * x, which stays below 3m, then bring it below m.
	always_comb begin
		addend  = y_q[N-1] ? {2'b00, x_q} : '0;
		sum     = {1'b0, r_q, 1'b0} + addend;
		m1      = {2'b00, m_q};
		m2      = {1'b0, m_q, 1'b0};
		if (sum >= m2) begin
			reduced = sum - m2;
		end else if (sum >= m1) begin
			reduced = sum - m1;
		end else begin
			reduced = sum;
		end
	end

	// Step counter and status flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Operand and partial result registers.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			y_q <= y;
			m_q <= m;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= reduced[N-1:0];
			y_q <= {y_q[N-2:0], 1'b0};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign product     = r_q;

endmodule

// ----- design/modular_exponentiation_unit.sv -----
// Work per item grows with N = OPERAND_BITS; a clear exponent bit skips the
// multiply and only squares. A zero modulus never starts the multiplier and sets
// finish_q straight away. One item is worked on at a time.
// The rate is set by the bit-serial multiplier, one multiplier bit per cycle,
// with one reduction plus up to two products for every exponent bit.
// Reset clears the sequencer and output valid; no result is pending after it.
module modular_exponentiation_unit #(
	parameter int unsigned OPERAND_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] base_value,
	input  logic [31:0] exponent_value,
	input  logic [31:0] modulus_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] power_result,
	output logic        zero_modulus_error
);

	localparam int unsigned N     = OPERAND_BITS;
	localparam int unsigned CNT_W = (N > 1) ? $clog2(N) : 1;

	mexp_pkg::seq_state_t  state_q;
	mexp_pkg::mul_status_t mul_st;

	logic [N-1:0]     base_q;
	logic [N-1:0]     exp_q;
	logic [N-1:0]     mod_q;
	logic [N-1:0]     acc_q;
	logic [CNT_W-1:0] bit_cnt_q;
	logic             finish_q;
	logic             err_q;
	logic [N-1:0]     result_q;
	logic             res_err_q;
	logic             out_valid_q;

	logic         accept;
	logic [N-1:0] in_base;
	logic [N-1:0] in_mod;
	logic         mul_start;
	logic [N-1:0] mul_x;
	logic [N-1:0] mul_y;
	logic [N-1:0] mul_m;
	logic [N-1:0] mul_p;
	logic         out_free;

	assign in_base  = base_value[N-1:0];
	assign in_mod   = modulus_value[N-1:0];
	assign in_stall = (state_q != mexp_pkg::S_IDLE) || finish_q;
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Multiplier requests: base reduction, acc * base, or base squared.
	always_comb begin
		mul_start = 1'b0;
		mul_x     = base_q;
		mul_y     = base_q;
		mul_m     = mod_q;
		unique case (state_q)
			mexp_pkg::S_IDLE: begin
				mul_start = accept && (in_mod != '0);
				mul_x     = N'(1);
				mul_y     = in_base;
				mul_m     = in_mod;
			end
			mexp_pkg::S_ISSUE: begin
				mul_start = 1'b1;
				if (exp_q[0]) begin
					mul_x = acc_q;
				end
			end
			mexp_pkg::S_MUL: begin
				mul_start = mul_st.done;
			end
			mexp_pkg::S_REDUCE, mexp_pkg::S_SQR: begin
				mul_start = 1'b0;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	mexp_mulmod #(
		.N(N)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.y      (mul_y),
		.m      (mul_m),
		.status (mul_st),
		.product(mul_p)
	);

	// Sequencer over the exponent bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mexp_pkg::S_IDLE;
			finish_q  <= 1'b0;
			bit_cnt_q <= '0;
		end else begin
			unique case (state_q)
				mexp_pkg::S_IDLE: begin
					if (finish_q) begin
						if (out_free) begin
							finish_q <= 1'b0;
						end
					end else if (accept) begin
						if (in_mod == '0) begin
							finish_q <= 1'b1;
						end else begin
							state_q <= mexp_pkg::S_REDUCE;
						end
					end
				end
				mexp_pkg::S_REDUCE: begin
					if (mul_st.done) begin
						bit_cnt_q <= CNT_W'(N - 1);
						state_q   <= mexp_pkg::S_ISSUE;
					end
				end
				mexp_pkg::S_ISSUE: begin
					state_q <= exp_q[0] ? mexp_pkg::S_MUL : mexp_pkg::S_SQR;
				end
				mexp_pkg::S_MUL: begin
					if (mul_st.done) begin
						state_q <= mexp_pkg::S_SQR;
					end
				end
				mexp_pkg::S_SQR: begin
					if (mul_st.done) begin
						if (bit_cnt_q == '0) begin
							state_q  <= mexp_pkg::S_IDLE;
							finish_q <= 1'b1;
						end else begin
							bit_cnt_q <= bit_cnt_q - 1'b1;
							state_q   <= mexp_pkg::S_ISSUE;
						end
					end
				end
				default: begin
					state_q <= mexp_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			exp_q <= exponent_value[N-1:0];
			mod_q <= in_mod;
			err_q <= (in_mod == '0);
			acc_q <= (in_mod == N'(1) || in_mod == '0) ? '0 : N'(1);
		end
		if (mul_st.done) begin
			unique case (state_q)
				mexp_pkg::S_MUL: begin
					acc_q <= mul_p;
				end
				mexp_pkg::S_REDUCE: begin
					base_q <= mul_p;
				end
				mexp_pkg::S_SQR: begin
					base_q <= mul_p;
					exp_q  <= {1'b0, exp_q[N-1:1]};
				end
				mexp_pkg::S_IDLE, mexp_pkg::S_ISSUE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Output register: loaded when a finished result meets a free output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_q && state_q == mexp_pkg::S_IDLE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_q && state_q == mexp_pkg::S_IDLE && out_free) begin
			result_q  <= acc_q;
			res_err_q <= err_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign power_result       = mexp_pkg::DATA_W'(result_q);
	assign zero_modulus_error = res_err_q;

	// The multiplier only runs while an item is being worked on.
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_st.busy |-> (state_q != mexp_pkg::S_IDLE))
		else $error("multiplier busy while sequencer idle");

	// A zero modulus never starts the multiplier and finishes at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_mod == '0) |=> (finish_q && !mul_st.busy))
		else $error("zero modulus not short-cut");

	// An error beat carries a zero result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && zero_modulus_error) |-> (power_result == '0))
		else $error("error beat with nonzero result");

endmodule
